FILE: rtl/sfp_pkg.sv
// Package for the sensor frame packer: command codes, frame byte sources,
// microcode word layout and the control program itself.
// Used by every module in rtl except sfp_ram; depends on nothing.
package sfp_pkg;

  // Width of the byte position field on the result channel.
  localparam int POS_W = 6;

  // Fill readings sent for off-board slots in single-board mode.
  localparam logic [15:0] PROX_FILL  = 16'd11111;
  localparam logic [15:0] FORCE_FILL = 16'd22222;

  // Request commands.
  typedef enum logic [2:0] {
    CMD_LOAD_PROX  = 3'd0,
    CMD_LOAD_FORCE = 3'd1,
    CMD_LOAD_GYRO  = 3'd2,
    CMD_LOAD_ACCEL = 3'd3,
    CMD_EMIT       = 3'd4
  } cmd_t;

  // Where the byte of a microcode step comes from.
  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_PROX_HI,
    SRC_MID,
    SRC_FORCE_LO,
    SRC_IMU_HI,
    SRC_IMU_LO,
    SRC_ZERO,
    SRC_HEADER,
    SRC_SUM
  } src_t;

  // How the step counter moves on.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_PAIR_MORE,
    COND_AXIS_MORE,
    COND_JUMP,
    COND_DONE
  } cond_t;

  typedef logic [3:0] step_t;

  // Fixed program addresses.
  localparam step_t STEP_FETCH   = 4'd0;
  localparam step_t STEP_PROX_HI = 4'd1;
  localparam step_t STEP_MID     = 4'd2;
  localparam step_t STEP_FRC_LO  = 4'd3;
  localparam step_t STEP_IMU_HI  = 4'd4;
  localparam step_t STEP_IMU_LO  = 4'd5;
  localparam step_t STEP_PAD     = 4'd6;
  localparam step_t STEP_HEADER  = 4'd7;
  localparam step_t STEP_SUM     = 4'd8;

  // One control word.
  typedef struct packed {
    src_t  src;       // byte source, SRC_NONE for a step with no output
    logic  data;      // byte lies in the data region of the frame
    logic  rd;        // issue a read of the slot stores
    logic  inc_pair;  // step on to the next slot pair
    logic  inc_axis;  // step on to the next IMU axis
    cond_t cond;
    step_t target;
  } ucode_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic   start;
    logic   fire;
    ucode_t uw;
  } seq_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic pair_last;
    logic axis_last;
    logic data_last;
    logic out_free;
  } dp_stat_t;

  // A load request passed from the top level to the stores.
  typedef struct packed {
    logic        en;
    logic [2:0]  cmd;
    logic [4:0]  slot;
    logic [15:0] sample;
  } load_req_t;

  // The frame program, one control word per step.
  function automatic ucode_t sfp_rom(input step_t step);
    ucode_t w;
    w = '{src: SRC_NONE, data: 1'b0, rd: 1'b0, inc_pair: 1'b0, inc_axis: 1'b0,
          cond: COND_DONE, target: STEP_FETCH};
    unique case (step)
      STEP_FETCH: begin
        w.rd   = 1'b1;
        w.cond = COND_NEXT;
      end
      STEP_PROX_HI: begin
        w.src  = SRC_PROX_HI;
        w.data = 1'b1;
        w.cond = COND_NEXT;
      end
      STEP_MID: begin
        w.src  = SRC_MID;
        w.data = 1'b1;
        w.cond = COND_NEXT;
      end
      STEP_FRC_LO: begin
        w.src      = SRC_FORCE_LO;
        w.data     = 1'b1;
        w.rd       = 1'b1;
        w.inc_pair = 1'b1;
        w.cond     = COND_PAIR_MORE;
        w.target   = STEP_PROX_HI;
      end
      STEP_IMU_HI: begin
        w.src  = SRC_IMU_HI;
        w.data = 1'b1;
        w.cond = COND_NEXT;
      end
      STEP_IMU_LO: begin
        w.src      = SRC_IMU_LO;
        w.data     = 1'b1;
        w.inc_axis = 1'b1;
        w.cond     = COND_AXIS_MORE;
        w.target   = STEP_IMU_HI;
      end
      STEP_PAD: begin
        w.src    = SRC_ZERO;
        w.data   = 1'b1;
        w.cond   = COND_JUMP;
        w.target = STEP_PAD;
      end
      STEP_HEADER: begin
        w.src  = SRC_HEADER;
        w.cond = COND_NEXT;
      end
      STEP_SUM: begin
        w.src  = SRC_SUM;
        w.cond = COND_DONE;
      end
      default: begin
        w.cond = COND_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/sfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sfp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sfp_sequencer.sv
// Microcode sequencer: step counter, control program lookup and jump logic.
// Depends on sfp_pkg.
module sfp_sequencer
  import sfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_stat_t  stat,
  output seq_ctrl_t ctrl,
  output logic      busy
);

  logic   running, running_next;
  step_t  step, step_next;
  ucode_t uw;
  logic   fire;

  assign uw   = sfp_rom(step);
  assign busy = running;

  // A step that emits a byte waits for room in the output register.
  assign fire = running && ((uw.src == SRC_NONE) || stat.out_free);

  assign ctrl = '{start: start, fire: fire, uw: uw};

  // Next step selection.
  always_comb begin
    running_next = running;
    step_next    = step;
    if (!running) begin
      if (start) begin
        running_next = 1'b1;
        step_next    = STEP_FETCH;
      end
    end else if (fire) begin
      if (uw.data && stat.data_last) begin
        // The data region is full: go straight to the header.
        step_next = STEP_HEADER;
      end else begin
        unique case (uw.cond)
          COND_NEXT:      step_next = step + 4'd1;
          COND_PAIR_MORE: step_next = stat.pair_last ? step + 4'd1 : uw.target;
          COND_AXIS_MORE: step_next = stat.axis_last ? step + 4'd1 : uw.target;
          COND_JUMP:      step_next = uw.target;
          COND_DONE:      running_next = 1'b0;
          default:        running_next = 1'b0;
        endcase
      end
    end
  end

  // Step counter and run flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= STEP_FETCH;
    end else begin
      running <= running_next;
      step    <= step_next;
    end
  end

endmodule

FILE: rtl/sfp_datapath.sv
// Datapath of the frame packer: reading stores, IMU words, frame counters,
// byte selection, checksum and the result output register.
// Depends on sfp_pkg and sfp_ram.
module sfp_datapath
  import sfp_pkg::*;
#(
  parameter int SENSOR_SLOTS   = 24,
  parameter int LOCAL_CHANNELS = 8,
  parameter int IMU_AXES       = 3,
  parameter int FRAME_BYTES    = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             board_mode,
  input  load_req_t        ld,
  input  seq_ctrl_t        ctrl,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       frame_byte,
  output logic [POS_W-1:0] byte_position,
  output logic             frame_last
);

  localparam int PAIRS = SENSOR_SLOTS / 2;
  localparam int SLOT_W = $clog2(SENSOR_SLOTS);
  localparam int AX_W = (IMU_AXES > 1) ? $clog2(IMU_AXES) : 1;

  logic [SLOT_W-1:0] pair;
  logic [AX_W-1:0]   axis;
  logic [POS_W-1:0]  pos;
  logic [7:0]        odd_sum;
  logic              half;

  logic [15:0] gyro  [IMU_AXES];
  logic [15:0] accel [IMU_AXES];
  logic [SENSOR_SLOTS-1:0] prox_vld, force_vld;

  logic [11:0]       prox_rd, force_rd;
  logic              prox_ok, force_ok, fill;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr, ld_addr;
  logic              ld_prox, ld_force, ld_slot_ok, ld_axis_ok;
  logic [AX_W-1:0]   ld_axis;
  logic [11:0]       prox_eff, force_eff;
  logic [15:0]       imu_word;
  logic [7:0]        byte_val;
  logic              emit;

  // Load decode.
  assign ld_slot_ok = 32'(ld.slot) < SENSOR_SLOTS;
  assign ld_axis_ok = 32'(ld.slot) < IMU_AXES;
  assign ld_addr    = SLOT_W'(ld.slot);
  assign ld_axis    = AX_W'(ld.slot);
  assign ld_prox    = ld.en && (ld.cmd == CMD_LOAD_PROX) && ld_slot_ok;
  assign ld_force   = ld.en && (ld.cmd == CMD_LOAD_FORCE) && ld_slot_ok;

  // Status back to the sequencer.
  assign stat.pair_last = pair == SLOT_W'(PAIRS - 1);
  assign stat.axis_last = axis == AX_W'(IMU_AXES - 1);
  assign stat.data_last = pos == POS_W'(FRAME_BYTES - 3);
  assign stat.out_free  = !out_valid || !out_stall;

  // Slot read: the current pair, or the next one when a pair is finishing.
  assign rd_en = ctrl.fire && ctrl.uw.rd && !(ctrl.uw.inc_pair && stat.pair_last);
  assign rd_addr = (half ? SLOT_W'(PAIRS) : '0) +
                   (ctrl.uw.inc_pair ? pair + SLOT_W'(1) : pair);

  sfp_ram #(.WIDTH(12), .DEPTH(SENSOR_SLOTS)) u_prox_ram (
    .clk   (clk),
    .we    (ld_prox),
    .waddr (ld_addr),
    .wdata (ld.sample[11:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (prox_rd)
  );

  sfp_ram #(.WIDTH(12), .DEPTH(SENSOR_SLOTS)) u_force_ram (
    .clk   (clk),
    .we    (ld_force),
    .waddr (ld_addr),
    .wdata (ld.sample[11:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (force_rd)
  );

  // Written flags for the slot stores; an unwritten slot reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      prox_vld  <= '0;
      force_vld <= '0;
    end else begin
      if (ld_prox) begin
        prox_vld[ld_addr] <= 1'b1;
      end
      if (ld_force) begin
        force_vld[ld_addr] <= 1'b1;
      end
    end
  end

  // Flags registered alongside the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      prox_ok  <= 1'b0;
      force_ok <= 1'b0;
      fill     <= 1'b0;
    end else if (rd_en) begin
      prox_ok  <= prox_vld[rd_addr];
      force_ok <= force_vld[rd_addr];
      fill     <= !board_mode && (32'(rd_addr) >= LOCAL_CHANNELS);
    end
  end

  // IMU word registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IMU_AXES; i++) begin
        gyro[i]  <= '0;
        accel[i] <= '0;
      end
    end else if (ld.en && ld_axis_ok) begin
      if (ld.cmd == CMD_LOAD_GYRO) begin
        gyro[ld_axis] <= ld.sample;
      end
      if (ld.cmd == CMD_LOAD_ACCEL) begin
        accel[ld_axis] <= ld.sample;
      end
    end
  end

  // Effective readings and the byte of the current step.
  assign prox_eff  = fill ? PROX_FILL[11:0] : (prox_ok ? prox_rd : 12'd0);
  assign force_eff = fill ? FORCE_FILL[11:0] : (force_ok ? force_rd : 12'd0);
  assign imu_word  = half ? accel[axis] : gyro[axis];

  always_comb begin
    case (ctrl.uw.src)
      SRC_PROX_HI:  byte_val = prox_eff[11:4];
      SRC_MID:      byte_val = {prox_eff[3:0], force_eff[11:8]};
      SRC_FORCE_LO: byte_val = force_eff[7:0];
      SRC_IMU_HI:   byte_val = imu_word[15:8];
      SRC_IMU_LO:   byte_val = imu_word[7:0];
      SRC_HEADER:   byte_val = {3'b000, board_mode, 3'b000, half};
      SRC_SUM:      byte_val = odd_sum;
      default:      byte_val = 8'd0;
    endcase
  end

  assign emit = ctrl.fire && (ctrl.uw.src != SRC_NONE);

  // Frame counters, checksum and the half toggle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair    <= '0;
      axis    <= '0;
      pos     <= '0;
      odd_sum <= '0;
      half    <= 1'b0;
    end else if (ctrl.start) begin
      pair    <= '0;
      axis    <= '0;
      pos     <= '0;
      odd_sum <= '0;
    end else if (ctrl.fire) begin
      if (ctrl.uw.inc_pair && !stat.pair_last) begin
        pair <= pair + SLOT_W'(1);
      end
      if (ctrl.uw.inc_axis && !stat.axis_last) begin
        axis <= axis + AX_W'(1);
      end
      if (emit) begin
        pos <= pos + POS_W'(1);
      end
      if (ctrl.uw.data && pos[0]) begin
        odd_sum <= odd_sum + byte_val;
      end
      if (ctrl.uw.src == SRC_SUM) begin
        half <= !half;
      end
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte    <= byte_val;
      byte_position <= pos;
      frame_last    <= ctrl.uw.src == SRC_SUM;
    end
  end

endmodule

FILE: rtl/sensor_frame_packer.sv
// Top level of the sensor frame packer: request decode, board mode register,
// sequencer and datapath. Depends on sfp_pkg, sfp_sequencer and sfp_datapath.
//
//  channel   handshake              payload
//  request   in_valid/in_stall      cmd[2:0], slot[4:0], sample[15:0]
//  result    out_valid/out_stall    frame_byte[7:0], byte_position[5:0], frame_last
//  config    cfg_we                 cfg_data (board mode)
//
// A load request does not raise in_stall. An emit request holds in_stall high
// until the frame is sent, so the next request is taken only after that: first
// the slot store read, then one frame byte per step of the microcode program.
// Reset is synchronous and clears the stores to zero through written flags.
// Output stalls hold the sequencer on the step that waits to emit; requests
// are stalled while a frame is being sent.
module sensor_frame_packer
  import sfp_pkg::*;
#(
  parameter int SENSOR_SLOTS   = 24,
  parameter int LOCAL_CHANNELS = 8,
  parameter int IMU_AXES       = 3,
  parameter int FRAME_BYTES    = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       cmd,
  input  logic [4:0]       slot,
  input  logic [15:0]      sample,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       frame_byte,
  output logic [POS_W-1:0] byte_position,
  output logic             frame_last
);

  logic      board_mode;
  logic      busy;
  logic      accept;
  logic      start;
  load_req_t ld;
  seq_ctrl_t ctrl;
  dp_stat_t  stat;

  // Board mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_mode <= 1'b0;
    end else if (cfg_we) begin
      board_mode <= cfg_data;
    end
  end

  // Request decode.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign start    = accept && (cmd == CMD_EMIT);
  assign ld       = '{en: accept, cmd: cmd, slot: slot, sample: sample};

  sfp_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  sfp_datapath #(
    .SENSOR_SLOTS   (SENSOR_SLOTS),
    .LOCAL_CHANNELS (LOCAL_CHANNELS),
    .IMU_AXES       (IMU_AXES),
    .FRAME_BYTES    (FRAME_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .board_mode    (board_mode),
    .ld            (ld),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .frame_last    (frame_last)
  );

endmodule
